### sv/pinhole_reprojection_error_top_assert.svh
// Assertion macros for the pinhole reprojection error block.
`ifndef PINHOLE_REPROJECTION_ERROR_TOP_ASSERT_SVH
`define PINHOLE_REPROJECTION_ERROR_TOP_ASSERT_SVH

// Property checked at every clock edge while reset is released.
`define PRE_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define PRE_ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/pre_pkg.sv
// Shared types, constants and the datapath program of the reprojection error block.
package pre_pkg;

    localparam int unsigned IN_W        = 160;
    localparam int unsigned OUT_W       = 96;
    localparam int unsigned ADDR_W      = 5;
    localparam int unsigned VIEW_SUM_W  = 48;
    localparam int unsigned TOTAL_SUM_W = 56;
    localparam int unsigned DIV_W       = 56;
    localparam int unsigned STEP_W      = 6;
    localparam int unsigned PROG_LEN    = 33;

    localparam logic [31:0] Q_ONE = 32'h0001_0000;

    localparam logic [2:0] REG_FOCAL_X   = 3'd0;
    localparam logic [2:0] REG_FOCAL_Y   = 3'd1;
    localparam logic [2:0] REG_PRINCIPAL = 3'd2;
    localparam logic [2:0] REG_K1        = 3'd3;
    localparam logic [2:0] REG_K2        = 3'd4;
    localparam logic [2:0] REG_K3        = 3'd5;
    localparam logic [2:0] REG_P1        = 3'd6;
    localparam logic [2:0] REG_P2        = 3'd7;

    typedef struct packed {
        logic [31:0] focal_x;
        logic [31:0] focal_y;
        logic [31:0] principal_point;
        logic [31:0] k1;
        logic [31:0] k2;
        logic [31:0] k3;
        logic [31:0] p1;
        logic [31:0] p2;
    } t_cfg;

    typedef enum logic [4:0] {
        OP_NOP, OP_LOAD, OP_DIVX, OP_DIVY, OP_DIVV, OP_DIVT, OP_MUL, OP_R2, OP_RXY,
        OP_ACC0, OP_ACC1, OP_TORAD, OP_TOXD, OP_TOYD, OP_DIFF, OP_ABS, OP_SQRT,
        OP_SUMS, OP_CLOSE
    } t_op;

    typedef enum logic [4:0] {
        SRC_XP, SRC_YP, SRC_XY, SRC_R2, SRC_R4, SRC_R6, SRC_RX, SRC_RY, SRC_RAD,
        SRC_XD, SRC_YD, SRC_K1, SRC_K2, SRC_K3, SRC_P1, SRC_P2, SRC_FX, SRC_FY,
        SRC_AU, SRC_AV
    } t_src;

    typedef enum logic [3:0] {
        DST_XX, DST_YY, DST_XY, DST_R4, DST_R6, DST_ACC, DST_ACC2, DST_U, DST_V,
        DST_SQ, DST_SQADD
    } t_dst;

    typedef struct packed {
        t_op  op;
        t_src a;
        t_src b;
        logic sh28;
        t_dst dst;
    } t_cmd;

    typedef struct packed {
        logic fault;
        logic last;
        logic div_done;
        logic sqrt_done;
    } t_status;

    function automatic t_cmd mk_cmd(t_op op, t_src a, t_src b, logic sh28, t_dst dst);
        t_cmd c;
        c.op   = op;
        c.a    = a;
        c.b    = b;
        c.sh28 = sh28;
        c.dst  = dst;
        return c;
    endfunction

    // A product is registered in r_prod first and then written from there to its destination register.
    function automatic t_cmd prog_cmd(logic [STEP_W-1:0] step);
        t_cmd c;
        c = mk_cmd(OP_NOP, SRC_XP, SRC_XP, 1'b0, DST_XX);
        case (step)
            6'd0:  c = mk_cmd(OP_MUL, SRC_XP, SRC_XP, 1'b0, DST_XX);
            6'd1:  c = mk_cmd(OP_MUL, SRC_YP, SRC_YP, 1'b0, DST_YY);
            6'd2:  c = mk_cmd(OP_MUL, SRC_XP, SRC_YP, 1'b0, DST_XY);
            6'd3:  c = mk_cmd(OP_R2, SRC_XP, SRC_XP, 1'b0, DST_XX);
            6'd4:  c = mk_cmd(OP_MUL, SRC_R2, SRC_R2, 1'b0, DST_R4);
            6'd5:  c = mk_cmd(OP_RXY, SRC_XP, SRC_XP, 1'b0, DST_XX);
            6'd6:  c = mk_cmd(OP_MUL, SRC_R4, SRC_R2, 1'b0, DST_R6);
            6'd7:  c = mk_cmd(OP_ACC1, SRC_XP, SRC_XP, 1'b0, DST_XX);
            6'd8:  c = mk_cmd(OP_MUL, SRC_K1, SRC_R2, 1'b1, DST_ACC);
            6'd9:  c = mk_cmd(OP_MUL, SRC_K2, SRC_R4, 1'b1, DST_ACC);
            6'd10: c = mk_cmd(OP_MUL, SRC_K3, SRC_R6, 1'b1, DST_ACC);
            6'd12: c = mk_cmd(OP_TORAD, SRC_XP, SRC_XP, 1'b0, DST_XX);
            6'd13: c = mk_cmd(OP_ACC0, SRC_XP, SRC_XP, 1'b0, DST_XX);
            6'd14: c = mk_cmd(OP_MUL, SRC_XP, SRC_RAD, 1'b0, DST_ACC);
            6'd15: c = mk_cmd(OP_MUL, SRC_P1, SRC_XY, 1'b1, DST_ACC2);
            6'd16: c = mk_cmd(OP_MUL, SRC_P2, SRC_RX, 1'b1, DST_ACC);
            6'd18: c = mk_cmd(OP_TOXD, SRC_XP, SRC_XP, 1'b0, DST_XX);
            6'd19: c = mk_cmd(OP_ACC0, SRC_XP, SRC_XP, 1'b0, DST_XX);
            6'd20: c = mk_cmd(OP_MUL, SRC_YP, SRC_RAD, 1'b0, DST_ACC);
            6'd21: c = mk_cmd(OP_MUL, SRC_P1, SRC_RY, 1'b1, DST_ACC);
            6'd22: c = mk_cmd(OP_MUL, SRC_P2, SRC_XY, 1'b1, DST_ACC2);
            6'd24: c = mk_cmd(OP_TOYD, SRC_XP, SRC_XP, 1'b0, DST_XX);
            6'd25: c = mk_cmd(OP_MUL, SRC_FX, SRC_XD, 1'b0, DST_U);
            6'd26: c = mk_cmd(OP_MUL, SRC_FY, SRC_YD, 1'b0, DST_V);
            6'd28: c = mk_cmd(OP_DIFF, SRC_XP, SRC_XP, 1'b0, DST_XX);
            6'd29: c = mk_cmd(OP_ABS, SRC_XP, SRC_XP, 1'b0, DST_XX);
            6'd30: c = mk_cmd(OP_MUL, SRC_AU, SRC_AU, 1'b0, DST_SQ);
            6'd31: c = mk_cmd(OP_MUL, SRC_AV, SRC_AV, 1'b0, DST_SQADD);
            default: ;
        endcase
        return c;
    endfunction

endpackage

### sv/pre_div.sv
// Restoring unsigned divider that retires one quotient bit per cycle.
module pre_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [pre_pkg::DIV_W-1:0] i_dividend,
    input  logic [31:0]              i_divisor,
    output logic                     o_done,
    output logic [pre_pkg::DIV_W-1:0] o_quot
);
    import pre_pkg::*;

    localparam int unsigned CNT_W = $clog2(DIV_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_W - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [31:0]      r_rem;
    logic [DIV_W-1:0] r_quot;
    logic [31:0]      r_div;
    logic [32:0]      trial;
    logic [32:0]      diff;
    logic             take;

    assign trial = {r_rem, r_quot[DIV_W-1]};
    assign diff  = trial - {1'b0, r_div};
    assign take  = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_dividend;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= take ? diff[31:0] : trial[31:0];
            r_quot <= {r_quot[DIV_W-2:0], take};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

### sv/pre_sqrt.sv
// Bit-serial integer square root of a 64-bit value, two radicand bits per cycle.
module pre_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_value,
    output logic        o_done,
    output logic [31:0] o_root
);
    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [63:0] r_s;
    logic [33:0] r_rem;
    logic [31:0] r_root;
    logic [35:0] rem2;
    logic [35:0] trial;
    logic        take;

    assign rem2  = {r_rem, r_s[63:62]};
    assign trial = {2'b00, r_root, 2'b01};
    assign take  = (rem2 >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_s    <= i_value;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_s    <= {r_s[61:0], 2'b00};
            r_rem  <= take ? 34'(rem2 - trial) : rem2[33:0];
            r_root <= {r_root[30:0], take};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

### sv/pre_datapath.sv
// Datapath: point registers, shared multiplier, divider, square root and error sums.
module pre_datapath #(
    parameter int VIEW_POINTS_MAX  = 4096,
    parameter int TOTAL_POINTS_MAX = 1048576
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  pre_pkg::t_cfg             i_cfg,
    input  pre_pkg::t_cmd             i_cmd,
    input  logic [pre_pkg::IN_W-1:0]  i_s_tdata,
    input  logic                      i_s_tlast,
    output pre_pkg::t_status          o_status,
    output logic [pre_pkg::OUT_W-1:0] o_m_tdata,
    output logic                      o_m_tlast,
    output logic                      o_m_tuser
);
    import pre_pkg::*;

    localparam int unsigned VCW = $clog2(VIEW_POINTS_MAX + 1);
    localparam int unsigned TCW = $clog2(TOTAL_POINTS_MAX + 1);
    localparam logic [VCW-1:0] VCNT_MAX = VCW'(VIEW_POINTS_MAX);
    localparam logic [TCW-1:0] TCNT_MAX = TCW'(TOTAL_POINTS_MAX);
    localparam logic signed [65:0] MAX66 = 66'sh0_7FFF_FFFF;
    localparam logic signed [65:0] MIN66 = -66'sh0_8000_0000;

    typedef enum logic [1:0] {DK_X, DK_Y, DK_V, DK_T} t_dkind;

    function automatic logic signed [31:0] clamp32(logic signed [65:0] x);
        logic signed [31:0] r;
        if (x > MAX66) r = 32'sh7FFF_FFFF;
        else if (x < MIN66) r = 32'sh8000_0000;
        else r = x[31:0];
        return r;
    endfunction

    function automatic logic [31:0] sat32(logic [DIV_W-1:0] q);
        logic [31:0] r;
        r = (q > DIV_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : q[31:0];
        return r;
    endfunction

    logic [31:0]          r_px, r_py, r_pz, r_mu, r_mv;
    logic                 r_last, r_fault;
    logic signed [31:0]   r_xp, r_yp, r_xx, r_yy, r_xy, r_r2, r_r4, r_r6;
    logic signed [31:0]   r_rx, r_ry, r_rad, r_xd, r_yd;
    logic signed [35:0]   r_acc;
    logic signed [49:0]   r_u, r_v;
    logic signed [50:0]   r_du, r_dv;
    logic [31:0]          r_au, r_av;
    logic                 r_big;
    logic [63:0]          r_sq;
    logic [31:0]          r_err, r_vmean, r_tmean;
    logic signed [65:0]   r_prod;
    logic                 r_wb_pend;
    t_dst                 r_wb_dst;
    logic                 r_wb_sh;
    t_dkind               r_dkind;
    logic [VIEW_SUM_W-1:0]  r_vsum;
    logic [TOTAL_SUM_W-1:0] r_tsum;
    logic [VCW-1:0]       r_vcnt;
    logic [TCW-1:0]       r_tcnt;
    logic [31:0]          r_o_err, r_o_vmean, r_o_tmean;
    logic                 r_o_last, r_o_fault;

    logic signed [32:0]   op_a, op_b;
    logic signed [65:0]   shifted;
    logic signed [31:0]   wb_val;
    logic [64:0]          sq_sum;
    logic [50:0]          abs_u, abs_v;
    logic [VIEW_SUM_W:0]  vsum_add;
    logic [TOTAL_SUM_W:0] tsum_add;
    logic                 div_start, div_done, sqrt_done;
    logic [DIV_W-1:0]     div_dividend, div_quot;
    logic [31:0]          div_divisor, sqrt_root, abs_px, abs_py;

    function automatic logic signed [32:0] src_val(t_src s);
        logic signed [32:0] r;
        case (s)
            SRC_XP:  r = 33'(r_xp);
            SRC_YP:  r = 33'(r_yp);
            SRC_XY:  r = 33'(r_xy);
            SRC_R2:  r = 33'(r_r2);
            SRC_R4:  r = 33'(r_r4);
            SRC_R6:  r = 33'(r_r6);
            SRC_RX:  r = 33'(r_rx);
            SRC_RY:  r = 33'(r_ry);
            SRC_RAD: r = 33'(r_rad);
            SRC_XD:  r = 33'(r_xd);
            SRC_YD:  r = 33'(r_yd);
            SRC_K1:  r = 33'($signed(i_cfg.k1));
            SRC_K2:  r = 33'($signed(i_cfg.k2));
            SRC_K3:  r = 33'($signed(i_cfg.k3));
            SRC_P1:  r = 33'($signed(i_cfg.p1));
            SRC_P2:  r = 33'($signed(i_cfg.p2));
            SRC_FX:  r = $signed({1'b0, i_cfg.focal_x});
            SRC_FY:  r = $signed({1'b0, i_cfg.focal_y});
            SRC_AU:  r = $signed({1'b0, r_au});
            SRC_AV:  r = $signed({1'b0, r_av});
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] div_clamp(logic [DIV_W-1:0] q, logic neg);
        logic signed [31:0] r;
        if (neg) r = (q > DIV_W'(32'h8000_0000)) ? 32'sh8000_0000 : -$signed(q[31:0]);
        else r = (q > DIV_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(q[31:0]);
        return r;
    endfunction

    always_comb begin
        op_a    = src_val(i_cmd.a);
        op_b    = src_val(i_cmd.b);
        shifted = r_wb_sh ? (r_prod >>> 28) : (r_prod >>> 16);
        wb_val  = clamp32(shifted);
        sq_sum  = {1'b0, r_sq} + {1'b0, r_prod[63:0]};
        abs_u   = r_du[50] ? 51'(-r_du) : 51'(r_du);
        abs_v   = r_dv[50] ? 51'(-r_dv) : 51'(r_dv);
        abs_px  = r_px[31] ? 32'(-r_px) : r_px;
        abs_py  = r_py[31] ? 32'(-r_py) : r_py;
        vsum_add = {1'b0, r_vsum} + (VIEW_SUM_W + 1)'(r_err);
        tsum_add = {1'b0, r_tsum} + (TOTAL_SUM_W + 1)'(r_err);
        div_start = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        case (i_cmd.op)
            OP_DIVX: begin
                div_start = 1'b1;
                div_dividend = {8'b0, abs_px, 16'b0};
                div_divisor  = r_pz;
            end
            OP_DIVY: begin
                div_start = 1'b1;
                div_dividend = {8'b0, abs_py, 16'b0};
                div_divisor  = r_pz;
            end
            OP_DIVV: begin
                div_start = 1'b1;
                div_dividend = DIV_W'(r_vsum);
                div_divisor  = 32'(r_vcnt);
            end
            OP_DIVT: begin
                div_start = 1'b1;
                div_dividend = DIV_W'(r_tsum);
                div_divisor  = 32'(r_tcnt);
            end
            default: ;
        endcase
    end

    pre_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    pre_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op == OP_SQRT),
        .i_value (r_sq),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_pend <= 1'b0;
            r_vsum    <= '0;
            r_tsum    <= '0;
            r_vcnt    <= '0;
            r_tcnt    <= '0;
        end else begin
            r_wb_pend <= (i_cmd.op == OP_MUL);
            if (i_cmd.op == OP_SUMS && !r_fault) begin
                if (r_vcnt < VCNT_MAX) begin
                    r_vsum <= vsum_add[VIEW_SUM_W] ? '1 : vsum_add[VIEW_SUM_W-1:0];
                    r_vcnt <= r_vcnt + 1'b1;
                end
                if (r_tcnt < TCNT_MAX) begin
                    r_tsum <= tsum_add[TOTAL_SUM_W] ? '1 : tsum_add[TOTAL_SUM_W-1:0];
                    r_tcnt <= r_tcnt + 1'b1;
                end
            end
            if (i_cmd.op == OP_CLOSE && r_last) begin
                r_vsum <= '0;
                r_vcnt <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_MUL) begin
            r_prod   <= op_a * op_b;
            r_wb_dst <= i_cmd.dst;
            r_wb_sh  <= i_cmd.sh28;
        end
        if (r_wb_pend) begin
            case (r_wb_dst)
                DST_XX:    r_xx <= wb_val;
                DST_YY:    r_yy <= wb_val;
                DST_XY:    r_xy <= wb_val;
                DST_R4:    r_r4 <= wb_val;
                DST_R6:    r_r6 <= wb_val;
                DST_ACC:   r_acc <= r_acc + 36'(wb_val);
                DST_ACC2:  r_acc <= r_acc + (36'(wb_val) <<< 1);
                DST_U:     r_u <= $signed(shifted[49:0]) +
                                  $signed({22'b0, i_cfg.principal_point[15:0], 12'b0});
                DST_V:     r_v <= $signed(shifted[49:0]) +
                                  $signed({22'b0, i_cfg.principal_point[31:16], 12'b0});
                DST_SQ:    r_sq <= r_prod[63:0];
                DST_SQADD: begin
                    r_sq  <= sq_sum[63:0];
                    r_big <= r_big | sq_sum[64];
                end
                default: ;
            endcase
        end
        if (div_done) begin
            case (r_dkind)
                DK_X: r_xp <= div_clamp(div_quot, r_px[31]);
                DK_Y: r_yp <= div_clamp(div_quot, r_py[31]);
                DK_V: r_vmean <= (r_vcnt == '0) ? '0 : sat32(div_quot);
                DK_T: r_tmean <= (r_tcnt == '0) ? '0 : sat32(div_quot);
                default: ;
            endcase
        end
        if (sqrt_done) begin
            r_err <= r_big ? 32'hFFFF_FFFF : sqrt_root;
        end
        case (i_cmd.op)
            OP_LOAD: begin
                r_px    <= i_s_tdata[31:0];
                r_py    <= i_s_tdata[63:32];
                r_pz    <= i_s_tdata[95:64];
                r_mu    <= i_s_tdata[127:96];
                r_mv    <= i_s_tdata[159:128];
                r_last  <= i_s_tlast;
                r_fault <= i_s_tdata[95] || (i_s_tdata[95:64] == '0);
                r_err   <= '0;
                r_big   <= 1'b0;
            end
            OP_DIVX:  r_dkind <= DK_X;
            OP_DIVY:  r_dkind <= DK_Y;
            OP_DIVV:  r_dkind <= DK_V;
            OP_DIVT:  r_dkind <= DK_T;
            OP_R2:    r_r2 <= clamp32(66'(r_xx) + 66'(r_yy));
            OP_RXY: begin
                r_rx <= clamp32(66'(r_r2) + (66'(r_xx) <<< 1));
                r_ry <= clamp32(66'(r_r2) + (66'(r_yy) <<< 1));
            end
            OP_ACC0:  r_acc <= '0;
            OP_ACC1:  r_acc <= $signed({4'b0, Q_ONE});
            OP_TORAD: r_rad <= clamp32(66'(r_acc));
            OP_TOXD:  r_xd <= clamp32(66'(r_acc));
            OP_TOYD:  r_yd <= clamp32(66'(r_acc));
            OP_DIFF: begin
                r_du <= 51'(r_u) - $signed({19'b0, r_mu});
                r_dv <= 51'(r_v) - $signed({19'b0, r_mv});
            end
            OP_ABS: begin
                r_au  <= abs_u[31:0];
                r_av  <= abs_v[31:0];
                r_big <= (|abs_u[50:32]) || (|abs_v[50:32]);
            end
            OP_CLOSE: begin
                r_o_err   <= r_err;
                r_o_vmean <= r_last ? r_vmean : '0;
                r_o_tmean <= r_tmean;
                r_o_last  <= r_last;
                r_o_fault <= r_fault;
            end
            default: ;
        endcase
    end

    assign o_status.fault     = r_fault;
    assign o_status.last      = r_last;
    assign o_status.div_done  = div_done;
    assign o_status.sqrt_done = sqrt_done;
    assign o_m_tdata = {r_o_tmean, r_o_vmean, r_o_err};
    assign o_m_tlast = r_o_last;
    assign o_m_tuser = r_o_fault;
endmodule

### sv/pre_ctrl.sv
// Controller that sequences the datapath through one point and runs both handshakes.
module pre_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    input  pre_pkg::t_status  i_status,
    output pre_pkg::t_cmd     o_cmd
);
    import pre_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DIVX, S_WAITX, S_DIVY, S_WAITY, S_PROG, S_SQRT, S_WAITSQ,
        S_SUMS, S_DIVV, S_WAITV, S_DIVT, S_WAITT, S_CLOSE
    } t_state;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(PROG_LEN - 1);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_s_tready, n_s_tready;
    logic              r_m_tvalid, n_m_tvalid;
    logic              close_ok;
    t_cmd              cmd;

    assign close_ok = !r_m_tvalid || i_m_tready;

    always_comb begin
        cmd        = mk_cmd(OP_NOP, SRC_XP, SRC_XP, 1'b0, DST_XX);
        n_state    = r_state;
        n_step     = r_step;
        n_s_tready = r_s_tready;
        n_m_tvalid = r_m_tvalid && !i_m_tready;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid && r_s_tready) begin
                    cmd.op     = OP_LOAD;
                    n_s_tready = 1'b0;
                    n_state    = S_DIVX;
                end
            end
            S_DIVX: begin
                if (i_status.fault) begin
                    n_state = S_SUMS;
                end else begin
                    cmd.op  = OP_DIVX;
                    n_state = S_WAITX;
                end
            end
            S_WAITX: if (i_status.div_done) n_state = S_DIVY;
            S_DIVY: begin
                cmd.op  = OP_DIVY;
                n_state = S_WAITY;
            end
            S_WAITY: begin
                if (i_status.div_done) begin
                    n_step  = '0;
                    n_state = S_PROG;
                end
            end
            S_PROG: begin
                cmd    = prog_cmd(r_step);
                n_step = r_step + 1'b1;
                if (r_step == STEP_LAST) n_state = S_SQRT;
            end
            S_SQRT: begin
                cmd.op  = OP_SQRT;
                n_state = S_WAITSQ;
            end
            S_WAITSQ: if (i_status.sqrt_done) n_state = S_SUMS;
            S_SUMS: begin
                cmd.op  = OP_SUMS;
                n_state = i_status.last ? S_DIVV : S_DIVT;
            end
            S_DIVV: begin
                cmd.op  = OP_DIVV;
                n_state = S_WAITV;
            end
            S_WAITV: if (i_status.div_done) n_state = S_DIVT;
            S_DIVT: begin
                cmd.op  = OP_DIVT;
                n_state = S_WAITT;
            end
            S_WAITT: if (i_status.div_done) n_state = S_CLOSE;
            S_CLOSE: begin
                if (close_ok) begin
                    cmd.op     = OP_CLOSE;
                    n_m_tvalid = 1'b1;
                    n_s_tready = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_step     <= '0;
            r_s_tready <= 1'b1;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_step     <= n_step;
            r_s_tready <= n_s_tready;
            r_m_tvalid <= n_m_tvalid;
        end
    end

    assign o_cmd      = cmd;
    assign o_s_tready = r_s_tready;
    assign o_m_tvalid = r_m_tvalid;
endmodule

### sv/pinhole_reprojection_error_top.sv
// Top level of the pinhole reprojection error block with its register file.
// Each input word is one camera-frame point with its measured pixel; the block
// returns one result word per point. A point goes through two bit-serial
// divisions for the perspective divide, a 33-step program on one shared 33x33
// multiplier, a bit-serial square root and a division for the overall mean,
// plus another division when the point closes a view. A point with
// non-positive depth skips the projection. The next point is taken as soon
// as the previous result is in the output register, even before it is read.
module pinhole_reprojection_error_top #(
    parameter int VIEW_POINTS_MAX  = 4096,
    parameter int TOTAL_POINTS_MAX = 1048576
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // point_x, point_y, point_depth, measured_u, measured_v
    input  logic [pre_pkg::IN_W-1:0]   i_s_axis_tdata,
    input  logic                       i_s_axis_tlast,
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    // point_error, view_mean_error, overall_mean_error
    output logic [pre_pkg::OUT_W-1:0]  o_m_axis_tdata,
    output logic                       o_m_axis_tlast,
    // depth_fault
    output logic                       o_m_axis_tuser,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pre_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import pre_pkg::*;

    t_cfg      r_cfg;
    t_cmd      cmd;
    t_status   status;
    logic      wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.focal_x         <= Q_ONE;
            r_cfg.focal_y         <= Q_ONE;
            r_cfg.principal_point <= '0;
            r_cfg.k1              <= '0;
            r_cfg.k2              <= '0;
            r_cfg.k3              <= '0;
            r_cfg.p1              <= '0;
            r_cfg.p2              <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_FOCAL_X:   r_cfg.focal_x         <= pwdata;
                REG_FOCAL_Y:   r_cfg.focal_y         <= pwdata;
                REG_PRINCIPAL: r_cfg.principal_point <= pwdata;
                REG_K1:        r_cfg.k1              <= pwdata;
                REG_K2:        r_cfg.k2              <= pwdata;
                REG_K3:        r_cfg.k3              <= pwdata;
                REG_P1:        r_cfg.p1              <= pwdata;
                REG_P2:        r_cfg.p2              <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_FOCAL_X:   prdata = r_cfg.focal_x;
            REG_FOCAL_Y:   prdata = r_cfg.focal_y;
            REG_PRINCIPAL: prdata = r_cfg.principal_point;
            REG_K1:        prdata = r_cfg.k1;
            REG_K2:        prdata = r_cfg.k2;
            REG_K3:        prdata = r_cfg.k3;
            REG_P1:        prdata = r_cfg.p1;
            REG_P2:        prdata = r_cfg.p2;
            default:       prdata = '0;
        endcase
    end

    pre_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    pre_datapath #(
        .VIEW_POINTS_MAX  (VIEW_POINTS_MAX),
        .TOTAL_POINTS_MAX (TOTAL_POINTS_MAX)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_cmd     (cmd),
        .i_s_tdata (i_s_axis_tdata),
        .i_s_tlast (i_s_axis_tlast),
        .o_status  (status),
        .o_m_tdata (o_m_axis_tdata),
        .o_m_tlast (o_m_axis_tlast),
        .o_m_tuser (o_m_axis_tuser)
    );
endmodule

### sv/pre_checker.sv
// Port-level checks for the reprojection error block and their binding.
`include "pinhole_reprojection_error_top_assert.svh"

module pre_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_s_axis_tvalid,
    input logic                      o_s_axis_tready,
    input logic                      o_m_axis_tvalid,
    input logic                      i_m_axis_tready,
    input logic [pre_pkg::OUT_W-1:0] o_m_axis_tdata,
    input logic                      o_m_axis_tlast,
    input logic                      o_m_axis_tuser
);
    `PRE_ASSERT_CLK(a_reset_clears_valid, i_clk, !i_rst_n |=> !o_m_axis_tvalid, "valid after reset")
    `PRE_ASSERT_RST(a_stall_holds, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata), "stalled word changed")
    `PRE_ASSERT_RST(a_fault_zero_error, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata[31:0] == 32'd0, "faulted point has an error")
    `PRE_ASSERT_RST(a_view_mean_only_at_end, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tlast |-> o_m_axis_tdata[63:32] == 32'd0, "view mean outside view end")
    `PRE_ASSERT_RST(a_no_instant_result, i_clk, i_rst_n, $rose(o_m_axis_tvalid) |-> !$past(i_s_axis_tvalid && o_s_axis_tready), "result right after accept")
endmodule

bind pinhole_reprojection_error_top pre_checker u_pre_checker (.*);
